FILE: sv/derq_pkg.sv
// Shared types and constants of the double-ended ring queue.
package derq_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 10;
   localparam int COUNT_W = 10;
   localparam int CAP_MAX = 1023;

   typedef enum logic [1:0] {
      PUSH_BACK  = 2'd0,
      PUSH_FRONT = 2'd1,
      POP_BACK   = 2'd2,
      POP_FRONT  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

FILE: sv/derq_req_if.sv
// Request channel: valid, ready and one request word.
interface derq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           req_type;
   logic signed [derq_pkg::VALUE_W-1:0]  in_value;

   modport source (output valid, output req_type, output in_value, input ready);
   modport sink (input valid, input req_type, input in_value, output ready);
endinterface

FILE: sv/derq_rsp_if.sv
// Response channel: valid, ready and one response word.
interface derq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [derq_pkg::VALUE_W-1:0]  out_value;
   logic [1:0]                           status;
   logic [derq_pkg::COUNT_W-1:0]         entry_count;
   logic                                 is_empty;
   logic                                 is_full;

   modport source (output valid, output out_value, output status, output entry_count,
                   output is_empty, output is_full, input ready);
   modport sink (input valid, input out_value, input status, input entry_count,
                 input is_empty, input is_full, output ready);
endinterface

FILE: sv/derq_ram.sv
// Slot store: one write port and one read port with registered read data.
module derq_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] slot_mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/double_ended_ring_queue.sv
// Top level of the double-ended ring queue.
//
// Each request word on req_chan pushes a value at the back or the front, or
// pops one from either end. Every request gives exactly one response word on
// rsp_chan with the popped value (zero otherwise), a status of ok, overflow or
// underflow, and the count, empty and full flags after the request. A failed
// push or pop leaves the queue unchanged.
// Indices and the pointer update are settled at the edge that accepts the
// request; the slot store is read at that edge and its registered read data
// forms the response in the following cycle; a new request is taken every
// cycle while rsp_chan.ready is high. The single read and write port of the
// store sets that rate. If the receiver stalls, the response holds and
// req_chan.ready follows rsp_chan.ready, so at most one response waits. Reset
// empties the queue and sets the capacity to DEPTH. A write on csr_we sets
// the capacity (zero acts as one, values above DEPTH act as DEPTH) and empties
// the queue; the user must make it only while the queue is idle (not checked).
module double_ended_ring_queue #(
   parameter int DEPTH      = 512,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   derq_req_if.sink                     req_chan,
   derq_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [derq_pkg::CAP_W-1:0]   csr_wdata
);

   localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW        = (IW > derq_pkg::CAP_W) ? IW : derq_pkg::CAP_W;
   localparam int CAP_RESET = (DEPTH > derq_pkg::CAP_MAX) ? derq_pkg::CAP_MAX : DEPTH;
   localparam int VW        = derq_pkg::VALUE_W;
   localparam int CW        = derq_pkg::COUNT_W;

   logic [IW-1:0]                 head_ff, head_in;
   logic [IW-1:0]                 tail_ff, tail_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [derq_pkg::CAP_W-1:0]    cap_ff, cap_in;

   logic                          rsp_valid_ff;
   derq_pkg::status_type          status_ff, status_in;
   logic [CW-1:0]                 rsp_count_ff;
   logic                          rsp_full_ff, rsp_full_in;
   logic                          pop_ok_ff, pop_ok_in;

   derq_pkg::req_kind_type        kind;
   logic                          accept;
   logic                          is_push;
   logic                          q_empty;
   logic                          q_full;
   logic [XW-1:0]                 cap_m1_x;
   logic [IW-1:0]                 cap_m1;
   logic [IW-1:0]                 tail_up, tail_down, head_up, head_down;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [IW-1:0]                 rd_addr;
   logic [DATA_WIDTH+VW-1:0]      wr_wide;
   logic [DATA_WIDTH-1:0]         rd_data;
   logic [DATA_WIDTH+VW-1:0]      rd_wide;
   logic [31:0]                   wdata_w;

   assign kind     = derq_pkg::req_kind_type'(req_chan.req_type);
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_push  = (kind == derq_pkg::PUSH_BACK) || (kind == derq_pkg::PUSH_FRONT);
   assign q_empty  = (count_ff == '0);
   assign q_full   = (count_ff >= CW'(cap_ff));

   assign cap_m1_x = XW'(cap_ff) - XW'(1);
   assign cap_m1   = cap_m1_x[IW-1:0];

   assign tail_up   = (tail_ff == cap_m1) ? '0 : tail_ff + IW'(1);
   assign tail_down = (tail_ff == '0) ? cap_m1 : tail_ff - IW'(1);
   assign head_up   = (head_ff == cap_m1) ? '0 : head_ff + IW'(1);
   assign head_down = (head_ff == '0) ? cap_m1 : head_ff - IW'(1);

   assign wr_wide = {{DATA_WIDTH{1'b0}}, req_chan.in_value};

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = derq_pkg::ST_OK;
      pop_ok_in   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rd_addr     = tail_ff;
      case (kind)
         derq_pkg::PUSH_BACK, derq_pkg::PUSH_FRONT: begin
            if (q_full) begin
               status_in = derq_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CW'(1);
               if (q_empty) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (kind == derq_pkg::PUSH_BACK) begin
                  tail_in = tail_up;
                  wr_addr = tail_up;
               end else begin
                  head_in = head_down;
                  wr_addr = head_down;
               end
            end
         end
         derq_pkg::POP_BACK, derq_pkg::POP_FRONT: begin
            if (q_empty) begin
               status_in = derq_pkg::ST_UNDERFLOW;
            end else begin
               pop_ok_in = 1'b1;
               count_in  = count_ff - CW'(1);
               if (kind == derq_pkg::POP_BACK) begin
                  rd_addr = tail_ff;
                  tail_in = tail_down;
               end else begin
                  rd_addr = head_ff;
                  head_in = head_up;
               end
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         default: begin
            status_in = derq_pkg::ST_OK;
         end
      endcase
      rsp_full_in = (count_in == CW'(cap_ff));
   end

   assign wdata_w = 32'(csr_wdata);

   always_comb begin
      if (csr_wdata == '0) begin
         cap_in = derq_pkg::CAP_W'(1);
      end else if (wdata_w > 32'(DEPTH)) begin
         cap_in = derq_pkg::CAP_W'(CAP_RESET);
      end else begin
         cap_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= derq_pkg::CAP_W'(CAP_RESET);
      end else if (csr_we) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= cap_in;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
         rsp_full_ff  <= rsp_full_in;
         pop_ok_ff    <= pop_ok_in;
      end
   end

   derq_ram #(
      .DEPTH (DEPTH),
      .AW    (IW),
      .DW    (DATA_WIDTH)
   ) u_derq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_wide[DATA_WIDTH-1:0]),
      .rd_en   (accept && pop_ok_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_wide = {{VW{1'b0}}, rd_data};

   assign req_chan.ready       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_value   = pop_ok_ff ? rd_wide[VW-1:0] : '0;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_empty    = (rsp_count_ff == '0);
   assign rsp_chan.is_full     = rsp_full_ff;

   // The count never exceeds the capacity in force.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cap_ff))
      else $error("entry count above capacity");

   // An empty queue always has both indices back at slot zero.
   a_empty_indices: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with indices away from zero");

   // Every accepted request leaves a response word pending.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted request without response");

   // A push into a full queue reports overflow.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (accept && is_push && q_full) |=> (rsp_chan.status == derq_pkg::ST_OVERFLOW))
      else $error("push into full queue not reported");

   // A pop from an empty queue reports underflow and returns zero.
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_push && q_empty) |=>
         (rsp_chan.status == derq_pkg::ST_UNDERFLOW) && (rsp_chan.out_value == '0))
      else $error("pop from empty queue not reported");

endmodule

FILE: tb/sv/double_ended_ring_queue_tb.sv
// Testbench of the double-ended ring queue: scoreboard class, stimulus tasks and top module.

typedef struct {
   logic signed [derq_pkg::VALUE_W-1:0] out_value;
   derq_pkg::status_type                status;
   logic [derq_pkg::COUNT_W-1:0]        entry_count;
   logic                                is_empty;
   logic                                is_full;
} derq_result_type;

class derq_scoreboard;
   localparam int SLOTS = 512;

   logic [derq_pkg::VALUE_W-1:0] slots [SLOTS];
   int unsigned        head;
   int unsigned        tail;
   int unsigned        count;
   int unsigned        cap;
   derq_result_type    expected_q [$];
   int unsigned        errors;
   int unsigned        reported;
   int unsigned        requests;
   int unsigned        overflows;
   int unsigned        underflows;
   int unsigned        fulls;

   function new();
      cap = SLOTS;
      head = 0;
      tail = 0;
      count = 0;
   endfunction

   function int unsigned next_index(input int unsigned idx);
      return (idx + 1 >= cap) ? 0 : idx + 1;
   endfunction

   function int unsigned prev_index(input int unsigned idx);
      return (idx == 0) ? cap - 1 : idx - 1;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void set_capacity(input logic [derq_pkg::CAP_W-1:0] value);
      if (value == 0)
         cap = 1;
      else if (value > SLOTS)
         cap = SLOTS;
      else
         cap = 32'(value);
      head = 0;
      tail = 0;
      count = 0;
   endfunction

   function void note_request(input derq_pkg::req_kind_type kind,
                              input logic [derq_pkg::VALUE_W-1:0] value);
      derq_result_type r;
      r.out_value = '0;
      r.status = derq_pkg::ST_OK;
      requests++;
      if (kind == derq_pkg::PUSH_BACK || kind == derq_pkg::PUSH_FRONT) begin
         if (count >= cap) begin
            r.status = derq_pkg::ST_OVERFLOW;
            overflows++;
         end else begin
            if (count == 0) begin
               head = 0;
               tail = 0;
               slots[0] = value;
            end else if (kind == derq_pkg::PUSH_BACK) begin
               tail = next_index(tail);
               slots[tail] = value;
            end else begin
               head = prev_index(head);
               slots[head] = value;
            end
            count++;
         end
      end else begin
         if (count == 0) begin
            r.status = derq_pkg::ST_UNDERFLOW;
            underflows++;
         end else begin
            if (kind == derq_pkg::POP_BACK) begin
               r.out_value = slots[tail];
               tail = prev_index(tail);
            end else begin
               r.out_value = slots[head];
               head = next_index(head);
            end
            count--;
            if (count == 0) begin
               head = 0;
               tail = 0;
            end
         end
      end
      r.entry_count = derq_pkg::COUNT_W'(count);
      r.is_empty = (count == 0);
      r.is_full = (count == cap);
      if (r.is_full)
         fulls++;
      expected_q.push_back(r);
   endfunction

   function bit field_differs(input string name, input logic [derq_pkg::VALUE_W-1:0] exp_v,
                              input logic [derq_pkg::VALUE_W-1:0] act_v);
      if (exp_v === act_v)
         return 0;
      if (reported < 100)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      reported++;
      return 1;
   endfunction

   function void check_response(input derq_result_type got);
      derq_result_type exp_r;
      bit              bad;
      if (expected_q.size() == 0) begin
         errors++;
         if (reported < 100)
            $display("%0t: response word with nothing expected, value %0h status %0h",
                     $time, got.out_value, got.status);
         reported++;
         return;
      end
      exp_r = expected_q.pop_front();
      bad = 0;
      bad |= field_differs("out_value", exp_r.out_value, got.out_value);
      bad |= field_differs("status", derq_pkg::VALUE_W'(exp_r.status),
                           derq_pkg::VALUE_W'(got.status));
      bad |= field_differs("entry_count", derq_pkg::VALUE_W'(exp_r.entry_count),
                           derq_pkg::VALUE_W'(got.entry_count));
      bad |= field_differs("is_empty", derq_pkg::VALUE_W'(exp_r.is_empty),
                           derq_pkg::VALUE_W'(got.is_empty));
      bad |= field_differs("is_full", derq_pkg::VALUE_W'(exp_r.is_full),
                           derq_pkg::VALUE_W'(got.is_full));
      if (bad)
         errors++;
   endfunction
endclass

module double_ended_ring_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [derq_pkg::CAP_W-1:0] csr_wdata;
   int                         send_idle_pct;
   int                         rsp_idle_pct;
   int unsigned                cycle_count;
   int unsigned                cap_writes;

   derq_req_if req_chan ();
   derq_rsp_if rsp_chan ();

   derq_scoreboard sb = new();

   double_ended_ring_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      derq_result_type got;
      if (!reset) begin
         if (csr_we)
            sb.set_capacity(csr_wdata);
         if (req_chan.valid && req_chan.ready)
            sb.note_request(derq_pkg::req_kind_type'(req_chan.req_type), req_chan.in_value);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_value = rsp_chan.out_value;
            got.status = derq_pkg::status_type'(rsp_chan.status);
            got.entry_count = rsp_chan.entry_count;
            got.is_empty = rsp_chan.is_empty;
            got.is_full = rsp_chan.is_full;
            sb.check_response(got);
         end
      end
   end

   function automatic logic [derq_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input derq_pkg::req_kind_type kind,
                            input logic [derq_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.in_value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_capacity(input logic [derq_pkg::CAP_W-1:0] value);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      cap_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int n);
      int                     push_pct;
      derq_pkg::req_kind_type kind;
      push_pct = 50;
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0)
            push_pct = ($urandom_range(2) == 0) ? 50 : (($urandom_range(1) != 0) ? 75 : 25);
         if ($urandom_range(99) < push_pct)
            kind = ($urandom_range(1) != 0) ? derq_pkg::PUSH_FRONT : derq_pkg::PUSH_BACK;
         else
            kind = ($urandom_range(1) != 0) ? derq_pkg::POP_FRONT : derq_pkg::POP_BACK;
         send_word(kind, random_value());
      end
   endtask

   task automatic fill_then_drain(input int n);
      for (int i = 0; i < n; i++)
         send_word(($urandom_range(1) != 0) ? derq_pkg::PUSH_FRONT : derq_pkg::PUSH_BACK,
                   random_value());
      for (int i = 0; i < n; i++)
         send_word(($urandom_range(1) != 0) ? derq_pkg::POP_FRONT : derq_pkg::POP_BACK,
                   random_value());
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= derq_pkg::PUSH_BACK;
      req_chan.in_value <= '0;
      cap_writes = 0;
      send_idle_pct = 21;
      rsp_idle_pct = 81;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset capacity: empty pops, pushes at both ends with the front wrapping, then drain.
      send_word(derq_pkg::POP_BACK, 32'h0000_0001);
      send_word(derq_pkg::POP_FRONT, 32'hFFFF_FFFF);
      send_word(derq_pkg::PUSH_BACK, 32'h7FFF_FFFF);
      send_word(derq_pkg::PUSH_FRONT, 32'h8000_0000);
      send_word(derq_pkg::PUSH_BACK, 32'h0000_0000);
      send_word(derq_pkg::PUSH_FRONT, 32'hFFFF_FFFF);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);
      send_word(derq_pkg::POP_BACK, 32'h0000_0000);
      send_word(derq_pkg::POP_BACK, 32'h0000_0000);
      send_word(derq_pkg::POP_BACK, 32'h0000_0000);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);

      // A written zero acts as a single slot.
      write_capacity(10'd0);
      send_word(derq_pkg::PUSH_FRONT, 32'h1234_5678);
      send_word(derq_pkg::PUSH_BACK, 32'h5555_5555);
      send_word(derq_pkg::PUSH_FRONT, 32'hAAAA_AAAA);
      send_word(derq_pkg::POP_BACK, 32'h0000_0000);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);

      write_capacity(10'd2);
      send_word(derq_pkg::PUSH_FRONT, 32'hA5A5_A5A5);
      send_word(derq_pkg::PUSH_FRONT, 32'h5A5A_5A5A);
      send_word(derq_pkg::PUSH_BACK, 32'h0F0F_0F0F);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);
      send_word(derq_pkg::PUSH_BACK, 32'hF0F0_F0F0);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);
      send_word(derq_pkg::POP_FRONT, 32'h0000_0000);
      send_word(derq_pkg::POP_BACK, 32'h0000_0000);

      write_capacity(10'd3);
      run_random(60);
      write_capacity(10'd1023);
      run_random(60);

      send_idle_pct = 81;
      rsp_idle_pct = 21;
      write_capacity(10'd8);
      run_random(60);
      write_capacity(10'd1);
      run_random(40);
      write_capacity(10'd2);
      run_random(40);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      write_capacity(10'd513);
      run_random(60);
      write_capacity(10'd40);
      fill_then_drain(41);
      write_capacity(10'd17);
      run_random(40);

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      $display("Sent %0d request words over %0d capacity writes, from one slot to the whole store.",
               sb.requests, cap_writes);
      $display("Saw %0d overflows, %0d underflows and %0d full results; %0d responses wrong.",
               sb.overflows, sb.underflows, sb.fulls, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
